// ===== hdl/pcrd_pkg.sv =====
// package for the prefix code rank decoder: constants, control word, program table
package pcrd_pkg;

	localparam int WORD_WIDTH_DEF = 32;
	localparam int MAX_RESULTS_DEF = 12;
	localparam int CNT_W = 24;
	localparam int RANK_W = 4;
	localparam int PC_W = 2;

	typedef logic [PC_W-1:0] pc_t;

	typedef enum logic [1:0] {
		COND_NEVER      = 2'd0,
		COND_NO_INPUT   = 2'd1,
		COND_DEC_MORE   = 2'd2,
		COND_FLUSH_WAIT = 2'd3
	} cond_t;

	typedef struct packed {
		logic  accept;
		logic  decode;
		logic  flush;
		cond_t cond;
		pc_t   target;
		pc_t   next;
	} ctl_t;

	typedef struct packed {
		logic no_input;
		logic dec_more;
		logic flush_wait;
	} sts_t;

	typedef struct packed {
		logic              valid;
		logic [RANK_W-1:0] rank;
		logic              last;
		logic              done;
	} push_t;

	localparam pc_t STEP_FETCH = 2'd0;
	localparam pc_t STEP_DECODE = 2'd1;
	localparam pc_t STEP_FLUSH = 2'd2;

	function automatic ctl_t prog_rom(input pc_t pc);
		ctl_t c;
		c = '{accept: 1'b0, decode: 1'b0, flush: 1'b0, cond: COND_NEVER,
			target: STEP_FETCH, next: STEP_FETCH};
		case (pc)
			STEP_FETCH: begin
				c.accept = 1'b1;
				c.cond = COND_NO_INPUT;
				c.target = STEP_FETCH;
				c.next = STEP_DECODE;
			end
			STEP_DECODE: begin
				c.decode = 1'b1;
				c.cond = COND_DEC_MORE;
				c.target = STEP_DECODE;
				c.next = STEP_FLUSH;
			end
			STEP_FLUSH: begin
				c.flush = 1'b1;
				c.cond = COND_FLUSH_WAIT;
				c.target = STEP_FLUSH;
				c.next = STEP_FETCH;
			end
			default: begin
				c.cond = COND_NEVER;
				c.next = STEP_FETCH;
			end
		endcase
		return c;
	endfunction

endpackage

// ===== hdl/pcrd_sequencer.sv =====
// microcode sequencer: step counter, program table lookup, conditional jumps
module pcrd_sequencer
	import pcrd_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  sts_t sts,
	output ctl_t ctl
);

	pc_t  pc_q;
	logic take;

	assign ctl = prog_rom(pc_q);

	always_comb begin
		case (ctl.cond)
			COND_NEVER:      take = 1'b0;
			COND_NO_INPUT:   take = sts.no_input;
			COND_DEC_MORE:   take = sts.dec_more;
			COND_FLUSH_WAIT: take = sts.flush_wait;
			default:         take = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= STEP_FETCH;
		end else begin
			pc_q <= take ? ctl.target : ctl.next;
		end
	end

endmodule

// ===== hdl/pcrd_datapath.sv =====
// decode datapath: word shifter, carry, bit budget, at most one code per decode step
module pcrd_datapath
	import pcrd_pkg::*;
#(
	parameter int WORD_WIDTH = WORD_WIDTH_DEF,
	parameter int MAX_RESULTS = MAX_RESULTS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  ctl_t                  ctl,
	input  logic                  in_valid,
	input  logic [WORD_WIDTH-1:0] word,
	input  logic                  cfg_we,
	input  logic [CNT_W-1:0]      cfg_data,
	input  logic                  out_free,
	output sts_t                  sts,
	output push_t                 push
);

	localparam int WL = $clog2(WORD_WIDTH + 1);
	localparam int CW = $clog2(MAX_RESULTS + 1);

	logic [WORD_WIDTH-1:0] sh_q;
	logic [WL-1:0]         wleft_q;
	logic [CNT_W-1:0]      rem_q;
	logic [3:0]            acc_q;
	logic [2:0]            n_q;
	logic [CW-1:0]         count_q;
	logic                  pend_valid_q;
	logic [RANK_W-1:0]     pend_rank_q;
	logic                  pend_done_q;

	logic [8:0]        win_ext;
	logic [4:0]        win;
	logic [2:0]        code_len;
	logic [2:0]        need;
	logic [RANK_W-1:0] code_rank;
	logic [WL-1:0]     avail;
	logic              partial;
	logic              word_end;
	logic              room;
	logic              emit_req;
	logic              blocked;
	logic              step_go;
	logic              stream_cut;
	logic [2:0]        n_new;
	logic [4:0]        win_shr;

	// window of the next five code bits: carried bits first, then word bits
	assign win_ext = {acc_q, sh_q[WORD_WIDTH-1 -: 5]} << (3'd4 - n_q);
	assign win = win_ext[8:4];

	always_comb begin
		if (!win[4]) begin
			code_len = 3'd3;
			code_rank = {2'b00, win[3:2]};
		end else if (!win[3]) begin
			code_len = 3'd4;
			code_rank = {2'b01, win[2:1]};
		end else begin
			code_len = 3'd5;
			code_rank = {1'b1, win[2:0]};
		end
	end

	assign need = code_len - n_q;
	assign avail = (rem_q < CNT_W'(wleft_q)) ? rem_q[WL-1:0] : wleft_q;
	assign partial = avail < WL'(need);
	assign word_end = partial || (avail == WL'(need));
	assign room = count_q < CW'(MAX_RESULTS);
	assign emit_req = ctl.decode && !partial && room;
	assign blocked = emit_req && pend_valid_q && !out_free;
	assign step_go = ctl.decode && !blocked;
	assign stream_cut = CNT_W'(avail) == rem_q;
	assign n_new = n_q + avail[2:0];
	assign win_shr = win >> (3'd5 - n_new);

	assign sts.no_input = !in_valid;
	assign sts.dec_more = blocked || !word_end;
	assign sts.flush_wait = pend_valid_q && !out_free;

	always_comb begin
		push.valid = 1'b0;
		push.rank = pend_rank_q;
		push.done = pend_done_q;
		push.last = 1'b0;
		if (ctl.flush && pend_valid_q && out_free) begin
			push.valid = 1'b1;
			push.last = 1'b1;
		end else if (emit_req && pend_valid_q && out_free) begin
			push.valid = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q <= '0;
			acc_q <= '0;
			n_q <= '0;
			wleft_q <= '0;
			count_q <= '0;
			pend_valid_q <= 1'b0;
		end else begin
			if (ctl.accept && in_valid) begin
				wleft_q <= WL'(WORD_WIDTH);
				count_q <= '0;
			end
			if (step_go) begin
				if (!partial) begin
					rem_q <= rem_q - CNT_W'(need);
					wleft_q <= wleft_q - WL'(need);
					acc_q <= '0;
					n_q <= '0;
					if (room) begin
						pend_valid_q <= 1'b1;
						count_q <= count_q + 1'b1;
					end
				end else begin
					rem_q <= rem_q - CNT_W'(avail);
					wleft_q <= '0;
					if (stream_cut) begin
						acc_q <= '0;
						n_q <= '0;
					end else begin
						acc_q <= win_shr[3:0];
						n_q <= n_new;
					end
				end
			end
			if (ctl.flush && pend_valid_q && out_free) begin
				pend_valid_q <= 1'b0;
			end
			if (cfg_we) begin
				rem_q <= cfg_data;
				acc_q <= '0;
				n_q <= '0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (ctl.accept && in_valid) begin
			sh_q <= word;
		end else if (step_go && !partial) begin
			sh_q <= sh_q << need;
		end
		if (step_go && !partial && room) begin
			pend_rank_q <= code_rank;
			pend_done_q <= rem_q == CNT_W'(need);
		end
	end

endmodule

// ===== hdl/prefix_code_rank_decoder_unit.sv =====
// top level of the prefix code rank decoder: sequencer, datapath, output register
// Decodes a stream of words, msb first, into 4-bit ranks (0xx: 0-3, 10xx: 4-7,
// 11xxx: 8-15), carrying an unfinished code across word boundaries. Writing
// total_bits starts a new stream of that many code bits; a code cut short at
// the stream end is dropped. A word takes one fetch step, one decode step per
// code completed in it, one more decode step when its bits run out inside a code
// or past the stream end (so at least one decode step), and one closing step.
// The decode step of the microcode sequencer completes one code per cycle unless the
// output is stalled. Each rank is held back one code so last_of_word can be marked.
module prefix_code_rank_decoder_unit
	import pcrd_pkg::*;
#(
	parameter int WORD_WIDTH = WORD_WIDTH_DEF,
	parameter int MAX_RESULTS = MAX_RESULTS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  total_bits_we,
	input  logic [CNT_W-1:0]      total_bits,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic [WORD_WIDTH-1:0] word,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic [RANK_W-1:0]     rank,
	output logic                  last_of_word,
	output logic                  stream_done
);

	ctl_t  ctl;
	sts_t  sts;
	push_t push;
	logic  out_valid_q;
	logic  out_free;
	logic [RANK_W-1:0] rank_q;
	logic  last_q;
	logic  done_q;

	pcrd_sequencer u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.sts    (sts),
		.ctl    (ctl)
	);

	pcrd_datapath #(
		.WORD_WIDTH  (WORD_WIDTH),
		.MAX_RESULTS (MAX_RESULTS)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (ctl),
		.in_valid (in_valid),
		.word     (word),
		.cfg_we   (total_bits_we),
		.cfg_data (total_bits),
		.out_free (out_free),
		.sts      (sts),
		.push     (push)
	);

	assign in_stall = !ctl.accept;
	assign out_free = !out_valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (push.valid) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (push.valid) begin
			rank_q <= push.rank;
			last_q <= push.last;
			done_q <= push.done;
		end
	end

	assign out_valid = out_valid_q;
	assign rank = rank_q;
	assign last_of_word = last_q;
	assign stream_done = done_q;

endmodule

// ===== sim/tb_prefix_code_rank_decoder_unit.sv =====
// self-checking testbench for prefix_code_rank_decoder_unit with its own rank predictor
`timescale 1ns / 100ps

module tb_prefix_code_rank_decoder_unit;
	import pcrd_pkg::*;

	localparam int SETTLE_CYCLES = 40;
	localparam int MAX_GAP = 8;
	localparam int ITEM_TARGET = 410;

	typedef struct packed {
		logic [RANK_W-1:0] rank;
		logic              last;
		logic              done;
	} rank_rec_t;

	logic                  clk;
	logic                  arst_n;
	logic                  total_bits_we;
	logic [CNT_W-1:0]      total_bits;
	logic                  in_valid;
	logic                  in_stall;
	logic [31:0]           word;
	logic                  out_valid;
	logic                  out_stall;
	logic [RANK_W-1:0]     rank;
	logic                  last_of_word;
	logic                  stream_done;

	// decoder state as predicted
	logic [CNT_W-1:0] bits_left;
	logic [3:0]       carry_acc;
	logic [2:0]       carry_len;

	rank_rec_t rank_q[$];
	logic      code_bits[$];
	rank_rec_t got_rec;
	rank_rec_t want_rec;
	int        fails;
	int        items_sent;
	int        tx_max;
	int        rx_max;
	int        rx_wait;
	int        hold_req;

	prefix_code_rank_decoder_unit u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.total_bits_we(total_bits_we),
		.total_bits   (total_bits),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.word         (word),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.rank         (rank),
		.last_of_word (last_of_word),
		.stream_done  (stream_done)
	);

	always begin
		clk = 1'b0;
		#2;
		clk = 1'b1;
		#2;
	end

	function automatic void decode_word(input logic [31:0] w);
		logic [4:0] acc;
		int         n;
		int         cnt;
		int         r;
		logic       have_pend;
		rank_rec_t  pend;
		acc = {1'b0, carry_acc};
		n = int'(carry_len);
		cnt = 0;
		have_pend = 1'b0;
		pend = '0;
		if (n > 4) begin
			n = 0;
			acc = '0;
		end
		for (int pos = 31; pos >= 0; pos--) begin
			if (bits_left == 0)
				break;
			bits_left = bits_left - 1'b1;
			acc = {acc[3:0], w[pos]};
			n++;
			r = -1;
			if (n == 3 && !acc[2])
				r = int'(acc[1:0]);
			else if (n == 4 && acc[3:2] == 2'b10)
				r = 4 + int'(acc[1:0]);
			else if (n == 5)
				r = 8 + int'(acc[2:0]);
			if (r >= 0) begin
				if (cnt < MAX_RESULTS_DEF) begin
					if (have_pend)
						rank_q.push_back(pend);
					pend.rank = r[RANK_W-1:0];
					pend.last = 1'b0;
					pend.done = (bits_left == 0);
					have_pend = 1'b1;
					cnt++;
				end
				acc = '0;
				n = 0;
			end else if (bits_left == 0) begin
				// code cut short by the stream end is dropped
				acc = '0;
				n = 0;
			end
		end
		carry_acc = acc[3:0];
		carry_len = n[2:0];
		if (have_pend) begin
			pend.last = 1'b1;
			rank_q.push_back(pend);
		end
	endfunction

	function automatic void append_code(input logic [3:0] r);
		if (r < 4) begin
			code_bits.push_back(1'b0);
		end else if (r < 8) begin
			code_bits.push_back(1'b1);
			code_bits.push_back(1'b0);
		end else begin
			code_bits.push_back(1'b1);
			code_bits.push_back(1'b1);
			code_bits.push_back(r[2]);
		end
		code_bits.push_back(r[1]);
		code_bits.push_back(r[0]);
	endfunction

	// receiver: per-rank random stall plus a long hold-off on request
	initial begin
		out_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req > 0) begin
				out_stall = 1'b1;
				hold_req--;
			end else if (rx_wait > 0) begin
				out_stall = 1'b1;
				rx_wait--;
			end else begin
				out_stall = 1'b0;
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			got_rec.rank = rank;
			got_rec.last = last_of_word;
			got_rec.done = stream_done;
			if (rank_q.size() == 0) begin
				fails++;
				if (fails <= 10)
					$display("unexpected rank word: rank %0d last %0b done %0b",
						got_rec.rank, got_rec.last, got_rec.done);
			end else begin
				want_rec = rank_q.pop_front();
				if (got_rec !== want_rec) begin
					fails++;
					if (fails <= 10)
						$display("rank word differs: expected rank %0d last %0b done %0b, got rank %0d last %0b done %0b",
							want_rec.rank, want_rec.last, want_rec.done,
							got_rec.rank, got_rec.last, got_rec.done);
				end
			end
			rx_wait = $urandom_range(0, rx_max);
		end
	end

	task automatic send_word(input logic [31:0] w);
		int gap;
		gap = $urandom_range(0, tx_max);
		repeat (gap) begin
			@(negedge clk);
			in_valid = 1'b0;
		end
		@(negedge clk);
		in_valid = 1'b1;
		word = w;
		do @(posedge clk); while (in_stall);
		decode_word(w);
		items_sent++;
	endtask

	task automatic send_bits(input int nwords);
		logic [31:0] w;
		int          idx;
		for (int i = 0; i < nwords; i++) begin
			for (int b = 31; b >= 0; b--) begin
				idx = i * 32 + (31 - b);
				w[b] = (idx < code_bits.size()) ? code_bits[idx] : 1'($urandom_range(0, 1));
			end
			send_word(w);
		end
	endtask

	task automatic wait_idle();
		@(negedge clk);
		in_valid = 1'b0;
		while (rank_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic load_total(input logic [CNT_W-1:0] v);
		wait_idle();
		@(negedge clk);
		total_bits_we = 1'b1;
		total_bits = v;
		@(negedge clk);
		total_bits_we = 1'b0;
		bits_left = v;
		carry_acc = '0;
		carry_len = '0;
	endtask

	task automatic test_stream_over_after_reset();
		tx_max = MAX_GAP;
		rx_max = MAX_GAP;
		send_word(32'h0000_0000);
		send_word(32'hffff_ffff);
		send_word($urandom());
	endtask

	task automatic test_every_rank();
		code_bits.delete();
		for (int r = 0; r < 16; r++)
			append_code(r[3:0]);
		for (int r = 15; r >= 0; r--)
			append_code(r[3:0]);
		load_total(CNT_W'(code_bits.size()));
		send_bits(5);
	endtask

	task automatic test_word_extremes();
		tx_max = 0;
		rx_max = 0;
		load_total('1);
		send_word(32'h0000_0000);
		send_word(32'hffff_ffff);
		send_word(32'h5555_5555);
		send_word(32'haaaa_aaaa);
		send_word(32'h8000_0000);
		send_word(32'h0000_0001);
		tx_max = MAX_GAP;
		rx_max = MAX_GAP;
	endtask

	task automatic test_stream_end();
		load_total(3);
		send_word(32'h2000_0000);
		send_word(32'hffff_ffff);
		// truncated long code
		load_total(4);
		send_word(32'hc000_0000);
		load_total(5);
		send_word(32'hc000_0000);
		load_total(1);
		send_word(32'h8000_0000);
		// code straddling into the first bit of the next word, the final bit of the stream
		load_total(33);
		send_word(32'h0000_0000);
		send_word(32'h0000_0000);
	endtask

	task automatic test_sender_pause();
		load_total('1);
		repeat (10) send_word($urandom());
		wait_idle();
		repeat (10) send_word($urandom());
	endtask

	task automatic test_backpressure();
		load_total('1);
		tx_max = 0;
		rx_max = MAX_GAP;
		hold_req = 300;
		repeat (30) send_word(($urandom_range(0, 1) == 0) ? 32'h0000_0000 : $urandom());
		tx_max = MAX_GAP;
	endtask

	task automatic random_stream();
		int               n;
		int               len;
		int               mode;
		int               k;
		int               nwords;
		logic [CNT_W-1:0] tot;
		tx_max = ($urandom_range(0, 4) == 0) ? 0 : MAX_GAP;
		rx_max = ($urandom_range(0, 4) == 0) ? 0 : MAX_GAP;
		code_bits.delete();
		if ($urandom_range(0, 7) == 0) begin
			// noise: raw words against an arbitrary bit count
			tot = CNT_W'($urandom_range(0, 400));
			load_total(tot);
			send_bits($urandom_range(1, 8));
		end else begin
			n = $urandom_range(1, 60);
			repeat (n) append_code(4'($urandom_range(0, 15)));
			len = code_bits.size();
			mode = $urandom_range(0, 9);
			if (mode <= 5) begin
				tot = CNT_W'(len);
			end else if (mode <= 7) begin
				k = $urandom_range(1, 4);
				tot = CNT_W'(len - k);
			end else if (mode == 8) begin
				tot = CNT_W'(len + $urandom_range(1, 64));
			end else begin
				tot = '1;
			end
			load_total(tot);
			nwords = (len + 31) / 32 + $urandom_range(0, 2);
			send_bits(nwords);
		end
	endtask

	task automatic test_random_streams();
		while (items_sent < ITEM_TARGET)
			random_stream();
	endtask

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		word = '0;
		total_bits_we = 1'b0;
		total_bits = '0;
		fails = 0;
		items_sent = 0;
		tx_max = MAX_GAP;
		rx_max = MAX_GAP;
		rx_wait = 0;
		hold_req = 0;
		bits_left = '0;
		carry_acc = '0;
		carry_len = '0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_stream_over_after_reset();
		test_every_rank();
		test_word_extremes();
		test_stream_end();
		test_sender_pause();
		test_backpressure();
		test_random_streams();

		wait_idle();
		if (fails == 0 && rank_q.size() == 0)
			$display("prefix_code_rank_decoder_unit: match");
		else
			$display("prefix_code_rank_decoder_unit: mismatch");
		$finish;
	end

	initial begin
		#2_000_000;
		$display("prefix_code_rank_decoder_unit: mismatch");
		$finish;
	end

endmodule
